// ===== rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Request and response types, operation and status codes, and the
// controller/datapath command interface of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int POS_W = 6;
    localparam int VAL_W = 32;
    localparam int CNT_W = 6;
    localparam int OP_W  = 3;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] element;
        logic [POS_W-1:0]        element_index;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } t_rsp;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LATCH,
        DP_DECIDE,
        DP_INS_PRIME,
        DP_INS_STEP,
        DP_DEL_PRIME,
        DP_DEL_STEP,
        DP_PUT,
        DP_DROP,
        DP_RESULT,
        DP_DUMP_RD,
        DP_DUMP_LD
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            err;
        logic            at_end;
        logic            del_tail;
        logic            empty;
        logic            ins_done;
        logic            del_done;
        logic            dump_last;
    } t_dp_stat;

endpackage

// ===== rtl/ple_ctrl.sv =====
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer of the positional list engine: handshakes, operation decode,
// shift and dump loops, response valid.
// ----------------------------------------------------------------------------
module ple_ctrl
    import ple_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    output logic     o_rsp_valid,
    input  logic     i_rsp_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_PRIME,
        S_INS_STEP,
        S_PUT,
        S_DEL_PRIME,
        S_DEL_STEP,
        S_DROP,
        S_FIN,
        S_DUMP_RD,
        S_DUMP_LD
    } t_state;

    t_state  r_state;
    logic    r_o_valid;
    logic    out_free;
    t_dp_cmd cmd;

    assign out_free    = !r_o_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_o_valid;
    assign o_cmd       = cmd;

    always_comb begin
        unique case (r_state)
            S_IDLE:      cmd = i_req_valid ? DP_LATCH : DP_NONE;
            S_DECIDE:    cmd = DP_DECIDE;
            S_INS_PRIME: cmd = DP_INS_PRIME;
            S_INS_STEP:  cmd = DP_INS_STEP;
            S_PUT:       cmd = DP_PUT;
            S_DEL_PRIME: cmd = DP_DEL_PRIME;
            S_DEL_STEP:  cmd = DP_DEL_STEP;
            S_DROP:      cmd = DP_DROP;
            S_FIN:       cmd = out_free ? DP_RESULT : DP_NONE;
            S_DUMP_RD:   cmd = DP_DUMP_RD;
            S_DUMP_LD:   cmd = out_free ? DP_DUMP_LD : DP_NONE;
            default:     cmd = DP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (cmd == DP_RESULT || cmd == DP_DUMP_LD) begin
                r_o_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (i_stat.err) begin
                        r_state <= S_FIN;
                    end else if (i_stat.op == OP_APPEND || i_stat.op == OP_INSERT) begin
                        r_state <= i_stat.at_end ? S_PUT : S_INS_PRIME;
                    end else if (i_stat.op == OP_DELETE) begin
                        r_state <= i_stat.del_tail ? S_DROP : S_DEL_PRIME;
                    end else if (i_stat.op == OP_DUMP) begin
                        r_state <= i_stat.empty ? S_FIN : S_DUMP_RD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_INS_PRIME: r_state <= S_INS_STEP;
                S_INS_STEP: begin
                    if (i_stat.ins_done) r_state <= S_PUT;
                end
                S_PUT:       r_state <= S_FIN;
                S_DEL_PRIME: r_state <= S_DEL_STEP;
                S_DEL_STEP: begin
                    if (i_stat.del_done) r_state <= S_DROP;
                end
                S_DROP:      r_state <= S_FIN;
                S_FIN: begin
                    if (out_free) r_state <= S_IDLE;
                end
                S_DUMP_RD:   r_state <= S_DUMP_LD;
                S_DUMP_LD: begin
                    if (out_free) r_state <= i_stat.dump_last ? S_IDLE : S_DUMP_RD;
                end
                default:     r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == S_DECIDE))
        else $error("accepted request not decoded next cycle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_rsp_ready) |-> (cmd != DP_RESULT && cmd != DP_DUMP_LD))
        else $error("response register overwritten while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd == DP_DUMP_LD && i_stat.dump_last) |=> o_req_ready)
        else $error("dump did not end on last element");

endmodule

// ===== rtl/ple_dp.sv =====
// ----------------------------------------------------------------------------
// ple_dp
// Datapath of the positional list engine: element memory, count, walk index,
// range and fullness checks, response register.
// ----------------------------------------------------------------------------
module ple_dp
    import ple_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_req     i_req,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output t_rsp     o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [VAL_W-1:0]  r_mem [CAPACITY];
    logic [VAL_W-1:0]  r_rd_data;
    t_req              r_req;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     r_pos;
    logic [ST_W-1:0]   r_status;
    t_rsp              r_out;

    logic [XW-1:0]     cnt_x;
    logic [XW-1:0]     idx_x;
    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     eff_pos;
    logic [ST_W-1:0]   dec_status;
    logic              is_put;
    logic              we;
    logic [AW-1:0]     wa;
    logic [VAL_W-1:0]  wd;
    logic              re;
    logic [AW-1:0]     ra;
    logic              ins_done;
    logic              del_done;
    logic              dump_last;

    assign cnt_x   = XW'(r_count);
    assign idx_x   = XW'(r_idx);
    assign pos_x   = XW'(r_req.position);
    assign eff_pos = (r_req.op == OP_APPEND) ? cnt_x : pos_x;
    assign is_put  = (r_req.op == OP_APPEND) || (r_req.op == OP_INSERT);

    always_comb begin
        dec_status = ST_OK;
        if (is_put) begin
            if (eff_pos > cnt_x) begin
                dec_status = ST_RANGE;
            end else if (cnt_x >= XW'(CAPACITY)) begin
                dec_status = ST_FULL;
            end
        end else if (r_req.op == OP_DELETE) begin
            if (pos_x >= cnt_x) dec_status = ST_RANGE;
        end
    end

    assign ins_done  = (idx_x == XW'(r_pos) + XW'(1));
    assign del_done  = (idx_x + XW'(2) == cnt_x);
    assign dump_last = (idx_x + XW'(1) == cnt_x);

    assign o_stat = '{
        op:        r_req.op,
        err:       (dec_status != ST_OK),
        at_end:    (eff_pos == cnt_x),
        del_tail:  (pos_x + XW'(1) == cnt_x),
        empty:     (r_count == '0),
        ins_done:  ins_done,
        del_done:  del_done,
        dump_last: dump_last
    };

    always_comb begin
        we = 1'b0;
        wa = r_idx;
        wd = r_rd_data;
        re = 1'b0;
        ra = r_idx;
        unique case (i_cmd)
            DP_INS_PRIME: begin
                re = 1'b1;
                ra = AW'(idx_x - XW'(1));
            end
            DP_INS_STEP: begin
                we = 1'b1;
                re = !ins_done;
                ra = AW'(idx_x - XW'(2));
            end
            DP_DEL_PRIME: begin
                re = 1'b1;
                ra = AW'(idx_x + XW'(1));
            end
            DP_DEL_STEP: begin
                we = 1'b1;
                re = !del_done;
                ra = AW'(idx_x + XW'(2));
            end
            DP_PUT: begin
                we = 1'b1;
                wa = r_pos;
                wd = r_req.value;
            end
            DP_DUMP_RD: begin
                re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        if (re) r_rd_data <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            unique case (i_cmd)
                DP_DECIDE: begin
                    if (r_req.op == OP_CLEAR) r_count <= '0;
                end
                DP_PUT:  r_count <= r_count + CW'(1);
                DP_DROP: r_count <= r_count - CW'(1);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            DP_LATCH: r_req <= i_req;
            DP_DECIDE: begin
                r_status <= dec_status;
                r_pos    <= eff_pos[AW-1:0];
                if (is_put) begin
                    r_idx <= cnt_x[AW-1:0];
                end else if (r_req.op == OP_DELETE) begin
                    r_idx <= pos_x[AW-1:0];
                end else begin
                    r_idx <= '0;
                end
            end
            DP_INS_STEP: begin
                if (!ins_done) r_idx <= r_idx - AW'(1);
            end
            DP_DEL_STEP: begin
                if (!del_done) r_idx <= r_idx + AW'(1);
            end
            DP_RESULT: begin
                r_out <= '{
                    status:        r_status,
                    element:       '0,
                    element_index: '0,
                    count:         CNT_W'(r_count),
                    last:          1'b1
                };
            end
            DP_DUMP_LD: begin
                r_out <= '{
                    status:        ST_OK,
                    element:       r_rd_data,
                    element_index: POS_W'(r_idx),
                    count:         CNT_W'(r_count),
                    last:          dump_last
                };
                if (!dump_last) r_idx <= r_idx + AW'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_rsp = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_PUT) |-> (cnt_x < XW'(CAPACITY) && XW'(r_pos) <= cnt_x))
        else $error("put into full store or past end");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_DUMP_LD) |-> (idx_x < cnt_x))
        else $error("dump index beyond count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_DROP) |-> (r_count != '0))
        else $error("delete from empty store");

endmodule

// ===== rtl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values with append, insert, delete,
// clear and dump requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_req_valid / o_req_ready carries op, position, value.
//   Response channel o_rsp_valid / i_rsp_ready carries status, element,
//   element_index, count, last. One request is in work at a time.
//   Append, insert, delete, clear and unknown ops give one response, last=1.
//   Clear, unknown ops, errors and dump of an empty list (one response) go
//   straight to the response. Insert shifts the count - pos entries from pos
//   up by one, append none; delete shifts the count - pos - 1 entries after
//   pos down by one. Each shifted entry is one read and one write of the
//   element memory. Dump of a non-empty list gives count responses, each a
//   memory read then a load of the response register, last=1 on the final
//   one.
//   The next request is taken once the previous one has reached the response
//   register; it may be processed while that response is still stalled, and
//   only the load of its own response waits for the receiver.
//   Reset empties the list; memory contents are not cleared.
// ----------------------------------------------------------------------------
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ple_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ple_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== test/positional_list_engine_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_engine_test
// Self-checking bench for the positional list engine. Requests are sent over
// the valid/ready channel with random gaps. A local list model predicts every
// response, and each response is compared field by field in arrival order.
// Directed runs cover the empty list, the value extremes, the head, middle
// and end positions, and a full store. Random runs mix epochs biased to
// growing and to shrinking the list.
// ----------------------------------------------------------------------------
module positional_list_engine_test;
    import ple_pkg::*;

    localparam int CAPACITY    = 32;
    localparam int HALF_PERIOD = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 64;
    localparam int EPOCH_LEN   = 50;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic i_rsp_ready = 1'b0;
    t_req i_req       = '0;
    logic o_req_ready;
    logic o_rsp_valid;
    t_rsp o_rsp;

    logic signed [VAL_W-1:0] list_mem [CAPACITY];
    int unsigned             list_len = 0;
    t_rsp                    expected_rsp [$];
    t_rsp                    want;
    int                      mismatch_count = 0;
    int                      cycle_count = 0;
    bit                      no_stall = 1'b0;

    positional_list_engine #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d responses pending", $time, expected_rsp.size());
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_rsp_ready <= no_stall || ($urandom_range(99) >= 8);
    end

    // list model
    function automatic logic [ST_W-1:0] place_value(int unsigned pos,
                                                    logic signed [VAL_W-1:0] val);
        int unsigned k;
        if (pos > list_len)
            return ST_RANGE;
        if (list_len >= CAPACITY)
            return ST_FULL;
        for (k = list_len; k > pos; k--)
            list_mem[k] = list_mem[k-1];
        list_mem[pos] = val;
        list_len++;
        return ST_OK;
    endfunction

    function automatic void predict_response(t_req req);
        t_rsp        rsp;
        int unsigned k;
        rsp        = '0;
        rsp.status = ST_OK;
        rsp.last   = 1'b1;
        case (req.op)
            OP_APPEND: rsp.status = place_value(list_len, req.value);
            OP_INSERT: rsp.status = place_value(req.position, req.value);
            OP_DELETE: begin
                if (req.position >= list_len) begin
                    rsp.status = ST_RANGE;
                end else begin
                    for (k = req.position; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            end
            OP_CLEAR: list_len = 0;
            OP_DUMP: begin
                if (list_len != 0) begin
                    for (k = 0; k < list_len; k++) begin
                        rsp.element       = list_mem[k];
                        rsp.element_index = k[POS_W-1:0];
                        rsp.count         = list_len[CNT_W-1:0];
                        rsp.last          = (k + 1 == list_len);
                        expected_rsp.push_back(rsp);
                    end
                    return;
                end
            end
            default: ;
        endcase
        rsp.count = list_len[CNT_W-1:0];
        expected_rsp.push_back(rsp);
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected response, expected none, actual %p", $time, o_rsp);
                mismatch_count++;
            end else begin
                want = expected_rsp.pop_front();
                check_field("status", want.status, o_rsp.status);
                check_field("element", want.element, o_rsp.element);
                check_field("element_index", want.element_index, o_rsp.element_index);
                check_field("count", want.count, o_rsp.count);
                check_field("last", want.last, o_rsp.last);
            end
        end
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(15))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input int unsigned pos,
                                input logic signed [VAL_W-1:0] val);
        t_req req;
        req.op       = op;
        req.position = POS_W'(pos);
        req.value    = val;
        while (!no_stall && $urandom_range(99) < 8) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= req;
        do @(posedge i_clk); while (o_req_ready !== 1'b1);
        predict_response(req);
    endtask

    task automatic wait_drained();
        i_req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_empty_list();
        logic [OP_W-1:0] op;
        send_request(OP_DUMP, $urandom, $urandom);
        send_request(OP_DELETE, 0, $urandom);
        send_request(OP_CLEAR, $urandom, $urandom);
        send_request(OP_INSERT, 1, $urandom);
        for (op = OP_DUMP + OP_W'(1); op != 0; op++)
            send_request(op, $urandom, $urandom);
        wait_drained();
    endtask

    task automatic test_positions();
        send_request(OP_APPEND, 6'h3F, 32'sh7FFF_FFFF);
        send_request(OP_APPEND, $urandom, 32'sh8000_0000);
        send_request(OP_INSERT, 0, -32'sd1);
        send_request(OP_INSERT, 3, '0);
        send_request(OP_INSERT, 1, 32'sd1);
        send_request(OP_INSERT, 6'h3F, $urandom);
        send_request(OP_DUMP, $urandom, $urandom);
        send_request(OP_DELETE, 2, $urandom);
        send_request(OP_DELETE, 0, $urandom);
        send_request(OP_DELETE, 2, $urandom);
        send_request(OP_DELETE, 2, $urandom);
        send_request(OP_DUMP, $urandom, $urandom);
        send_request(OP_CLEAR, $urandom, $urandom);
        send_request(OP_DUMP, $urandom, $urandom);
        wait_drained();
    endtask

    task automatic test_full_store();
        int k;
        for (k = 0; k < CAPACITY; k++)
            send_request(OP_APPEND, $urandom, pick_value());
        send_request(OP_APPEND, $urandom, $urandom);
        send_request(OP_INSERT, 5, $urandom);
        send_request(OP_INSERT, CAPACITY, $urandom);
        send_request(OP_INSERT, CAPACITY + 1, $urandom);
        send_request(OP_DELETE, CAPACITY, $urandom);
        send_request(OP_DELETE, 6'h3F, $urandom);
        send_request(OP_DUMP, $urandom, $urandom);
        send_request(OP_DELETE, CAPACITY - 1, $urandom);
        send_request(OP_INSERT, CAPACITY - 1, 32'sh8000_0000);
        send_request(OP_DELETE, 0, $urandom);
        send_request(OP_DUMP, $urandom, $urandom);
        wait_drained();
    endtask

    task automatic run_epoch(input bit grow);
        int          n;
        int unsigned sel;
        int unsigned pos;
        for (n = 0; n < EPOCH_LEN; n++) begin
            sel = $urandom_range(99);
            if ($urandom_range(99) < 15)
                pos = $urandom;
            else if (sel < (grow ? 75 : 35))
                pos = $urandom_range(list_len);
            else
                pos = (list_len == 0) ? 0 : $urandom_range(list_len - 1);
            if (sel < (grow ? 40 : 15))
                send_request(OP_APPEND, $urandom, pick_value());
            else if (sel < (grow ? 75 : 35))
                send_request(OP_INSERT, pos, pick_value());
            else if (sel < (grow ? 85 : 75))
                send_request(OP_DELETE, pos, $urandom);
            else if (sel < 95)
                send_request(OP_DUMP, $urandom, $urandom);
            else if (sel < 97)
                send_request(OP_CLEAR, $urandom, $urandom);
            else
                send_request(OP_W'($urandom_range((1 << OP_W) - 1, OP_DUMP + 1)),
                             $urandom, $urandom);
        end
    endtask

    task automatic test_random();
        run_epoch(1'b1);
        no_stall = 1'b1;
        run_epoch(1'b1);
        no_stall = 1'b0;
        run_epoch(1'b0);
        wait_drained();
        run_epoch(1'b1);
        run_epoch(1'b0);
        run_epoch(1'b0);
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_positions();
        test_full_store();
        test_random();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && expected_rsp.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
